### src/vla_pkg.sv
// Package for the look-at view matrix block: shared types and pipeline constants.
// No dependencies; the top level, the normalization unit and the testbench import it.
package vla_pkg;

   // One 32-bit signed word, Q16.16 on the way in, Q2.30 or Q16.16 on the way out.
   typedef logic signed [31:0] word_type;

   // Data that rides alongside a normalization unit to the next part of the datapath.
   typedef struct packed {
      word_type [2:0] eye;
      word_type [2:0] hint;
      word_type [2:0] fwd;
      word_type [2:0] side;
   } tag_type;

   // What travels next to the data inside a normalization unit.
   typedef struct packed {
      tag_type    tag;
      logic [2:0] neg;
   } side_type;

   // One root bit per square-root stage, one quotient bit per divider stage.
   localparam int SQRT_STEPS = 32;
   localparam int QUO_BITS   = 31;

   // Magnitude, maximum, leading-one search, scaling, squaring, summing, then the root
   // stages, the dividend stage, the divider stages and the sign stage.
   localparam int UNIT_LAT = 8 + SQRT_STEPS + QUO_BITS;

   // Fixed-point constants.
   localparam int AXIS_FRAC  = 30;
   localparam int ROUND_BIAS = 1 << 29;

endpackage

### src/vla_req_if.sv
// Request channel interface: valid/ready handshake plus the eye, target and up-hint words.
// Standalone; all payload words are signed Q16.16.
interface vla_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] eye_x;
   logic signed [31:0] eye_y;
   logic signed [31:0] eye_z;
   logic signed [31:0] aim_x;
   logic signed [31:0] aim_y;
   logic signed [31:0] aim_z;
   logic signed [31:0] hint_x;
   logic signed [31:0] hint_y;
   logic signed [31:0] hint_z;

   modport source (output valid, eye_x, eye_y, eye_z, aim_x, aim_y, aim_z,
                   hint_x, hint_y, hint_z, input ready);
   modport sink (input valid, eye_x, eye_y, eye_z, aim_x, aim_y, aim_z,
                 hint_x, hint_y, hint_z, output ready);
endinterface

### src/vla_rsp_if.sv
// Response channel interface: valid/ready handshake plus the three axes and translations.
// Standalone; axes are signed Q2.30, translations signed Q16.16.
interface vla_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] side_x;
   logic signed [31:0] side_y;
   logic signed [31:0] side_z;
   logic signed [31:0] upv_x;
   logic signed [31:0] upv_y;
   logic signed [31:0] upv_z;
   logic signed [31:0] fwd_x;
   logic signed [31:0] fwd_y;
   logic signed [31:0] fwd_z;
   logic signed [31:0] shift_side;
   logic signed [31:0] shift_up;
   logic signed [31:0] shift_fwd;

   modport source (output valid, side_x, side_y, side_z, upv_x, upv_y, upv_z,
                   fwd_x, fwd_y, fwd_z, shift_side, shift_up, shift_fwd, input ready);
   modport sink (input valid, side_x, side_y, side_z, upv_x, upv_y, upv_z,
                 fwd_x, fwd_y, fwd_z, shift_side, shift_up, shift_fwd, output ready);
endinterface

### src/view_matrix_look_at.sv
// Look-at view matrix: accepts one request transaction per cycle while the output register
// is free or its response is being taken. Three normalization units of 71 stages each
// (among them 32 square-root stages and 31 divider stages) make up most of the pipeline.
// Reset is synchronous and active high; it clears every valid bit, so the pipeline is
// empty after reset. Payload registers are not reset.
module view_matrix_look_at import vla_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   vla_req_if.sink   req_ch,
   vla_rsp_if.source rsp_ch
);

   // The whole pipeline moves as one. It advances whenever the output register is
   // empty or its transaction is being taken, so bubbles never stall an item and a
   // stall never drops or duplicates one: every stage holds while adv is low.
   logic adv;

   logic           in_v_ff;
   word_type [2:0] eye_ff, aim_ff, hint_ff;

   logic [2:0][63:0] dir_vec;
   tag_type          tag_a_in;
   logic             va_out;
   word_type [2:0]   fwd_a;
   tag_type          tag_a;

   logic                v_p1_ff, v_d1_ff;
   logic signed [63:0]  p1_ff [6];
   tag_type             tag_p1_ff, tag_d1_ff;
   logic [2:0][63:0]    d1_ff;

   logic            vb_out;
   word_type [2:0]  side_b;
   tag_type         tag_b;

   logic                v_p2_ff, v_d2_ff;
   logic signed [63:0]  p2_ff [6];
   tag_type             tag_p2_ff, tag_d2_ff;
   logic [2:0][63:0]    d2_ff;

   logic            vc_out;
   word_type [2:0]  upv_c;
   tag_type         tag_c;

   logic                v_tp_ff, v_ts_ff;
   logic signed [63:0]  tp_ff [3][3];
   word_type            ax_tp_ff [3][3];
   word_type            ax_ts_ff [3][3];
   logic signed [65:0]  ts_ff [3];

   logic     rsp_valid_ff;
   word_type rsp_ax_ff [3][3];
   word_type rsp_sh_ff [3];
   logic signed [35:0] tq [3];

   assign adv          = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (adv) begin
         in_v_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         eye_ff  <= {req_ch.eye_z, req_ch.eye_y, req_ch.eye_x};
         aim_ff  <= {req_ch.aim_z, req_ch.aim_y, req_ch.aim_x};
         hint_ff <= {req_ch.hint_z, req_ch.hint_y, req_ch.hint_x};
      end
   end

   // Forward direction is eye minus target, exact in 33 bits.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dir_vec[i] = {{32{eye_ff[i][31]}}, eye_ff[i]} - {{32{aim_ff[i][31]}}, aim_ff[i]};
      end
      tag_a_in      = '0;
      tag_a_in.eye  = eye_ff;
      tag_a_in.hint = hint_ff;
   end

   vla_unit u_norm_fwd (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (in_v_ff),
      .in_vec    (dir_vec),
      .in_tag    (tag_a_in),
      .out_valid (va_out),
      .out_vec   (fwd_a),
      .out_tag   (tag_a)
   );

   // Side direction: hint cross forward. Products are registered, then differenced.
   // Product pair i holds a[i+1]*b[i+2] and a[i+2]*b[i+1].
   always_ff @(posedge clock) begin
      if (reset) begin
         v_p1_ff <= 1'b0;
         v_d1_ff <= 1'b0;
      end else if (adv) begin
         v_p1_ff <= va_out;
         v_d1_ff <= v_p1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            p1_ff[2*i]   <= $signed(tag_a.hint[(i+1)%3]) * $signed(fwd_a[(i+2)%3]);
            p1_ff[2*i+1] <= $signed(tag_a.hint[(i+2)%3]) * $signed(fwd_a[(i+1)%3]);
            d1_ff[i]     <= p1_ff[2*i] - p1_ff[2*i+1];
         end
         tag_p1_ff <= '{eye: tag_a.eye, hint: tag_a.hint, fwd: fwd_a, side: tag_a.side};
         tag_d1_ff <= tag_p1_ff;
      end
   end

   vla_unit u_norm_side (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v_d1_ff),
      .in_vec    (d1_ff),
      .in_tag    (tag_d1_ff),
      .out_valid (vb_out),
      .out_vec   (side_b),
      .out_tag   (tag_b)
   );

   // True up direction: forward cross side, built the same way.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_p2_ff <= 1'b0;
         v_d2_ff <= 1'b0;
      end else if (adv) begin
         v_p2_ff <= vb_out;
         v_d2_ff <= v_p2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            p2_ff[2*i]   <= $signed(tag_b.fwd[(i+1)%3]) * $signed(side_b[(i+2)%3]);
            p2_ff[2*i+1] <= $signed(tag_b.fwd[(i+2)%3]) * $signed(side_b[(i+1)%3]);
            d2_ff[i]     <= p2_ff[2*i] - p2_ff[2*i+1];
         end
         tag_p2_ff <= '{eye: tag_b.eye, hint: tag_b.hint, fwd: tag_b.fwd, side: side_b};
         tag_d2_ff <= tag_p2_ff;
      end
   end

   vla_unit u_norm_up (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v_d2_ff),
      .in_vec    (d2_ff),
      .in_tag    (tag_d2_ff),
      .out_valid (vc_out),
      .out_vec   (upv_c),
      .out_tag   (tag_c)
   );

   // Translations: axis order is side, up, forward. Each is the negated eye dot
   // axis in Q20.46, biased by half an output step, then floored to Q16.16.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_tp_ff <= 1'b0;
         v_ts_ff <= 1'b0;
      end else if (adv) begin
         v_tp_ff <= vc_out;
         v_ts_ff <= v_tp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            ax_tp_ff[0][i] <= tag_c.side[i];
            ax_tp_ff[1][i] <= upv_c[i];
            ax_tp_ff[2][i] <= tag_c.fwd[i];
            tp_ff[0][i]    <= $signed(tag_c.eye[i]) * $signed(tag_c.side[i]);
            tp_ff[1][i]    <= $signed(tag_c.eye[i]) * $signed(upv_c[i]);
            tp_ff[2][i]    <= $signed(tag_c.eye[i]) * $signed(tag_c.fwd[i]);
         end
         ax_ts_ff <= ax_tp_ff;
         for (int a = 0; a < 3; a++) begin
            ts_ff[a] <= 66'(ROUND_BIAS)
                        - {{2{tp_ff[a][0][63]}}, tp_ff[a][0]}
                        - {{2{tp_ff[a][1][63]}}, tp_ff[a][1]}
                        - {{2{tp_ff[a][2][63]}}, tp_ff[a][2]};
         end
      end
   end

   // Floor by an arithmetic shift, then saturate to 32 bits.
   always_comb begin
      for (int a = 0; a < 3; a++) tq[a] = ts_ff[a][65:30];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v_ts_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ax_ff <= ax_ts_ff;
         for (int a = 0; a < 3; a++) begin
            if (tq[a][35:31] == 5'b00000 || tq[a][35:31] == 5'b11111) begin
               rsp_sh_ff[a] <= tq[a][31:0];
            end else if (tq[a][35]) begin
               rsp_sh_ff[a] <= 32'sh8000_0000;
            end else begin
               rsp_sh_ff[a] <= 32'sh7FFF_FFFF;
            end
         end
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.side_x     = rsp_ax_ff[0][0];
   assign rsp_ch.side_y     = rsp_ax_ff[0][1];
   assign rsp_ch.side_z     = rsp_ax_ff[0][2];
   assign rsp_ch.upv_x      = rsp_ax_ff[1][0];
   assign rsp_ch.upv_y      = rsp_ax_ff[1][1];
   assign rsp_ch.upv_z      = rsp_ax_ff[1][2];
   assign rsp_ch.fwd_x      = rsp_ax_ff[2][0];
   assign rsp_ch.fwd_y      = rsp_ax_ff[2][1];
   assign rsp_ch.fwd_z      = rsp_ax_ff[2][2];
   assign rsp_ch.shift_side = rsp_sh_ff[0];
   assign rsp_ch.shift_up   = rsp_sh_ff[1];
   assign rsp_ch.shift_fwd  = rsp_sh_ff[2];

endmodule

### src/vla_unit.sv
// Pipelined vector normalization unit: scales a 3-vector to a Q2.30 unit vector.
// Depends on vla_pkg; takes one vector per cycle while adv is high, else holds.
module vla_unit import vla_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  logic [2:0][63:0]       in_vec,
   input  tag_type                in_tag,
   output logic                   out_valid,
   output word_type [2:0]         out_vec,
   output tag_type                out_tag
);

   logic                valid_ff [UNIT_LAT];
   side_type            side_ff  [UNIT_LAT];

   logic [63:0]         mag1_ff [3];
   logic [63:0]         mag2_ff [3];
   logic [63:0]         max2_ff;
   logic [63:0]         mag3_ff [3];
   logic [5:0]          pos3_ff;
   logic [30:0]         mag4_ff [3];
   logic [30:0]         mag5_ff [3];
   logic [61:0]         sq5_ff  [3];

   logic [63:0]         rem_ff  [SQRT_STEPS+1];
   logic [31:0]         root_ff [SQRT_STEPS+1];
   logic [30:0]         smag_ff [SQRT_STEPS+1][3];

   logic [61:0]         drem_ff [QUO_BITS+1][3];
   logic [30:0]         quo_ff  [QUO_BITS+1][3];
   logic [31:0]         dn_ff   [QUO_BITS+1];
   logic                zero_ff [QUO_BITS+1];

   word_type            out_ff  [3];

   logic [63:0]         max_in;
   logic [63:0]         max01;
   logic [5:0]          pos_in;
   logic [63:0]         scaled [3];

   // Valid bits and side data travel in lockstep with the data stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < UNIT_LAT; s++) valid_ff[s] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < UNIT_LAT; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0].tag <= in_tag;
         for (int i = 0; i < 3; i++) side_ff[0].neg[i] <= in_vec[i][63];
         for (int s = 1; s < UNIT_LAT; s++) side_ff[s] <= side_ff[s-1];
      end
   end

   // Magnitudes, their maximum and the position of its leading one.
   always_comb begin
      max01  = (mag1_ff[0] > mag1_ff[1]) ? mag1_ff[0] : mag1_ff[1];
      max_in = (max01 > mag1_ff[2]) ? max01 : mag1_ff[2];
   end

   always_comb begin
      pos_in = '0;
      for (int b = 0; b < 64; b++) begin
         if (max2_ff[b]) pos_in = 6'(b);
      end
   end

   // Bring the largest magnitude into [2^30, 2^31); scaling down truncates.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (pos3_ff > 6'(AXIS_FRAC)) begin
            scaled[i] = mag3_ff[i] >> (pos3_ff - 6'(AXIS_FRAC));
         end else begin
            scaled[i] = mag3_ff[i] << (6'(AXIS_FRAC) - pos3_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            mag1_ff[i] <= in_vec[i][63] ? (64'd0 - in_vec[i]) : in_vec[i];
            mag2_ff[i] <= mag1_ff[i];
            mag3_ff[i] <= mag2_ff[i];
            mag4_ff[i] <= scaled[i][30:0];
            mag5_ff[i] <= mag4_ff[i];
            sq5_ff[i]  <= 62'(mag4_ff[i]) * 62'(mag4_ff[i]);
         end
         max2_ff <= max_in;
         pos3_ff <= pos_in;
         rem_ff[0]  <= 64'(sq5_ff[0]) + 64'(sq5_ff[1]) + 64'(sq5_ff[2]);
         root_ff[0] <= '0;
         smag_ff[0] <= mag5_ff;
      end
   end

   // Square root, one result bit per stage, kept as remainder and partial root.
   for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqrt
      localparam int B = SQRT_STEPS - k;
      logic [65:0] trial;

      always_comb trial = (66'(root_ff[k-1]) << (B + 1)) | (66'd1 << (2 * B));

      always_ff @(posedge clock) begin
         if (adv) begin
            if (66'(rem_ff[k-1]) >= trial) begin
               rem_ff[k]  <= rem_ff[k-1] - trial[63:0];
               root_ff[k] <= root_ff[k-1] | (32'd1 << B);
            end else begin
               rem_ff[k]  <= rem_ff[k-1];
               root_ff[k] <= root_ff[k-1];
            end
            smag_ff[k] <= smag_ff[k-1];
         end
      end
   end

   // Dividend with round-to-nearest bias; a zero root marks the zero vector.
   always_ff @(posedge clock) begin
      if (adv) begin
         dn_ff[0]   <= root_ff[SQRT_STEPS];
         zero_ff[0] <= (root_ff[SQRT_STEPS] == '0);
         for (int i = 0; i < 3; i++) begin
            drem_ff[0][i] <= (62'(smag_ff[SQRT_STEPS][i]) << AXIS_FRAC)
                             + 62'(root_ff[SQRT_STEPS] >> 1);
            quo_ff[0][i]  <= '0;
         end
      end
   end

   // Restoring division, one quotient bit per stage for all three lanes.
   for (genvar j = 1; j <= QUO_BITS; j++) begin : g_div
      localparam int B = QUO_BITS - j;
      logic [62:0] dsub;

      always_comb dsub = 63'(dn_ff[j-1]) << B;

      always_ff @(posedge clock) begin
         if (adv) begin
            dn_ff[j]   <= dn_ff[j-1];
            zero_ff[j] <= zero_ff[j-1];
            for (int i = 0; i < 3; i++) begin
               if ({1'b0, drem_ff[j-1][i]} >= dsub) begin
                  drem_ff[j][i] <= drem_ff[j-1][i] - dsub[61:0];
                  quo_ff[j][i]  <= quo_ff[j-1][i] | (31'd1 << B);
               end else begin
                  drem_ff[j][i] <= drem_ff[j-1][i];
                  quo_ff[j][i]  <= quo_ff[j-1][i];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            if (zero_ff[QUO_BITS]) begin
               out_ff[i] <= '0;
            end else if (side_ff[UNIT_LAT-2].neg[i]) begin
               out_ff[i] <= 32'd0 - 32'(quo_ff[QUO_BITS][i]);
            end else begin
               out_ff[i] <= 32'(quo_ff[QUO_BITS][i]);
            end
         end
      end
   end

   assign out_valid = valid_ff[UNIT_LAT-1];
   assign out_tag   = side_ff[UNIT_LAT-1].tag;
   always_comb begin
      for (int i = 0; i < 3; i++) out_vec[i] = out_ff[i];
   end

endmodule

### src/vla_checker.sv
// Port-level checker for the look-at view matrix block, with its bind statement.
// Depends only on the top level's ports.
module vla_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_fwd_x,
   input logic [31:0] rsp_shift_fwd
);

   // A response transaction that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // Its forward x axis and forward translation hold too.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_fwd_x) && $stable(rsp_shift_fwd))
      else $error("response payload changed while stalled");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // With the output register free, the pipeline must accept.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused while output is empty");

   // The forward x axis never exceeds one in magnitude.
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_fwd_x) <= 32'sd1073741824)
                 && ($signed(rsp_fwd_x) >= -32'sd1073741824))
      else $error("forward axis outside unit range");

endmodule

bind view_matrix_look_at vla_checker u_vla_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_fwd_x     (rsp_ch.fwd_x),
   .rsp_shift_fwd (rsp_ch.shift_fwd)
);

### sim/view_matrix_look_at_tb.sv
// Testbench for the look-at view matrix block: directed table, then random transactions.
// Depends on view_matrix_look_at, vla_pkg, vla_req_if and vla_rsp_if from the source folder.
module view_matrix_look_at_tb;
   import vla_pkg::*;

   // One request transaction and one response transaction as plain words.
   typedef struct {
      word_type eye_x, eye_y, eye_z, aim_x, aim_y, aim_z, hint_x, hint_y, hint_z;
   } view_req_type;

   typedef struct {
      word_type side_x, side_y, side_z, upv_x, upv_y, upv_z, fwd_x, fwd_y, fwd_z;
      word_type shift_side, shift_up, shift_fwd;
   } view_rsp_type;

   // A directed row: the request plus, when has_known is set, the response typed in by hand.
   typedef struct {
      view_req_type req;
      bit           has_known;
      view_rsp_type known;
   } view_row_type;

   localparam longint CYCLE_LIMIT = 3000000;
   localparam int     DRAIN_WAIT  = 300;
   localparam int     RANDOM_ITEMS = 1750;
   localparam word_type MAXW = 32'sh7fffffff;
   localparam word_type MINW = 32'sh80000000;
   localparam word_type ONE_AXIS = 32'sh40000000;
   localparam word_type ONE_POS  = 32'sh00010000;

   logic   clock;
   logic   reset;
   longint cycle_count;
   int     fail_count;
   int     idle_pct_req;
   int     idle_pct_rsp;
   bit     hold_rsp;

   vla_req_if req_ch ();
   vla_rsp_if rsp_ch ();

   view_matrix_look_at dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   // Store of the matrices still to come out of the pipeline, oldest first.
   view_rsp_type pending_views[$];

   initial begin
      clock = 1'b0;
      forever begin
         #6 clock = ~clock;
      end
   end

   // Integer square root of a 64-bit value, bit by bit.
   function automatic longint unsigned root_floor(input longint unsigned s);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= res + b) begin
            s = s - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Scale a vector so its largest magnitude sits in [2^30, 2^31) and make it unit length
   // in Q2.30. A zero vector stays zero.
   function automatic void make_unit(input longint v[3], output longint u[3]);
      longint unsigned mag[3];
      bit              neg[3];
      longint unsigned top, sq, n, q;
      top = 0;
      sq = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = v[i] < 0;
         mag[i] = neg[i] ? 64'd0 - longint'(v[i]) : v[i];
         if (mag[i] > top) top = mag[i];
      end
      if (top == 0) begin
         u[0] = 0; u[1] = 0; u[2] = 0;
         return;
      end
      while (top >= (64'd1 << 31)) begin
         top = top >> 1;
         for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      end
      while (top < (64'd1 << 30)) begin
         top = top << 1;
         for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      end
      for (int i = 0; i < 3; i++) sq = sq + mag[i] * mag[i];
      n = root_floor(sq);
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << 30) + (n >> 1)) / n;
         u[i] = neg[i] ? -longint'(q) : longint'(q);
      end
   endfunction

   function automatic void cross_of(input longint a[3], input longint b[3],
                                    output longint r[3]);
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   // Minus eye dot axis, rounded to Q16.16 toward minus infinity after the half bias,
   // then saturated to 32 bits. Products fit easily in 64 bits (2^31 * 2^30 * 3).
   function automatic word_type eye_shift(input longint eye[3], input longint ax[3]);
      longint t, q;
      t = -(eye[0] * ax[0] + eye[1] * ax[1] + eye[2] * ax[2]) + ROUND_BIAS;
      q = t >>> AXIS_FRAC;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return word_type'(q);
   endfunction

   // Predicts the view matrix rows and translations for one request.
   function automatic view_rsp_type predict_view(input view_req_type r);
      longint eye[3], hint[3], dir[3], tmp[3], fwd[3], side[3], upv[3];
      view_rsp_type o;
      eye[0] = longint'(r.eye_x); eye[1] = longint'(r.eye_y); eye[2] = longint'(r.eye_z);
      hint[0] = longint'(r.hint_x); hint[1] = longint'(r.hint_y);
      hint[2] = longint'(r.hint_z);
      dir[0] = eye[0] - longint'(r.aim_x);
      dir[1] = eye[1] - longint'(r.aim_y);
      dir[2] = eye[2] - longint'(r.aim_z);
      make_unit(dir, fwd);
      cross_of(hint, fwd, tmp);
      make_unit(tmp, side);
      cross_of(fwd, side, tmp);
      make_unit(tmp, upv);
      o.side_x = word_type'(side[0]); o.side_y = word_type'(side[1]);
      o.side_z = word_type'(side[2]);
      o.upv_x = word_type'(upv[0]); o.upv_y = word_type'(upv[1]);
      o.upv_z = word_type'(upv[2]);
      o.fwd_x = word_type'(fwd[0]); o.fwd_y = word_type'(fwd[1]);
      o.fwd_z = word_type'(fwd[2]);
      o.shift_side = eye_shift(eye, side);
      o.shift_up = eye_shift(eye, upv);
      o.shift_fwd = eye_shift(eye, fwd);
      return o;
   endfunction

   function automatic view_req_type make_req(input word_type ex, ey, ez, ax, ay, az,
                                             hx, hy, hz);
      view_req_type r;
      r.eye_x = ex; r.eye_y = ey; r.eye_z = ez;
      r.aim_x = ax; r.aim_y = ay; r.aim_z = az;
      r.hint_x = hx; r.hint_y = hy; r.hint_z = hz;
      return r;
   endfunction

   function automatic word_type rand_word();
      case ($urandom_range(0, 5))
         0: return MAXW;
         1: return MINW;
         2: return word_type'($urandom_range(0, 16)) - 8;
         3: return word_type'($urandom) >>> $urandom_range(0, 31);
         default: return word_type'($urandom);
      endcase
   endfunction

   // Mostly ordinary camera setups with random content; the rest are degenerate or wild.
   function automatic view_req_type rand_req();
      view_req_type r;
      r = make_req(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                   rand_word(), rand_word(), rand_word(), rand_word());
      case ($urandom_range(0, 9))
         0: begin
            r.aim_x = r.eye_x; r.aim_y = r.eye_y; r.aim_z = r.eye_z;
         end
         1: begin
            r.hint_x = r.eye_x - r.aim_x; r.hint_y = r.eye_y - r.aim_y;
            r.hint_z = r.eye_z - r.aim_z;
         end
         2: begin
            r.hint_x = 0; r.hint_y = 0; r.hint_z = 0;
         end
         3, 4, 5: begin
            r.eye_x = word_type'($urandom) >>> 8; r.eye_y = word_type'($urandom) >>> 8;
            r.eye_z = word_type'($urandom) >>> 8; r.aim_x = word_type'($urandom) >>> 8;
            r.aim_y = word_type'($urandom) >>> 8; r.aim_z = word_type'($urandom) >>> 8;
            r.hint_x = 0; r.hint_y = ONE_POS; r.hint_z = 0;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic check_word(input string label, input word_type want, input word_type got,
                             inout bit bad);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %h, actual %h", $time, label, want, got);
         bad = 1'b1;
      end
   endtask

   // Response side: compare each accepted transaction with the oldest expectation.
   always @(posedge clock) begin
      view_rsp_type want;
      bit           bad;
      bad = 1'b0;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_views.size() == 0) begin
            $display("%0t unexpected response transaction", $time);
            fail_count <= fail_count + 1;
         end else begin
            want = pending_views.pop_front();
            check_word("side_x", want.side_x, rsp_ch.side_x, bad);
            check_word("side_y", want.side_y, rsp_ch.side_y, bad);
            check_word("side_z", want.side_z, rsp_ch.side_z, bad);
            check_word("upv_x", want.upv_x, rsp_ch.upv_x, bad);
            check_word("upv_y", want.upv_y, rsp_ch.upv_y, bad);
            check_word("upv_z", want.upv_z, rsp_ch.upv_z, bad);
            check_word("fwd_x", want.fwd_x, rsp_ch.fwd_x, bad);
            check_word("fwd_y", want.fwd_y, rsp_ch.fwd_y, bad);
            check_word("fwd_z", want.fwd_z, rsp_ch.fwd_z, bad);
            check_word("shift_side", want.shift_side, rsp_ch.shift_side, bad);
            check_word("shift_up", want.shift_up, rsp_ch.shift_up, bad);
            check_word("shift_fwd", want.shift_fwd, rsp_ch.shift_fwd, bad);
            if (bad) fail_count <= fail_count + 1;
         end
      end
   end

   // Receiver: random stalls by phase; a long hold-off is counted here when requested.
   initial begin
      int held;
      rsp_ch.ready <= 1'b0;
      held = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp && held < 600) begin
            held++;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (!hold_rsp) held = 0;
            rsp_ch.ready <= ($urandom_range(1, 100) > idle_pct_rsp);
         end
      end
   end

   // Cycle counter and timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL view_matrix_look_at");
         $finish;
      end
   end

   // Offer one transaction, with random idle cycles first, and hold it until accepted.
   task automatic send_req(input view_req_type r);
      while ($urandom_range(1, 100) <= idle_pct_req) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.eye_x <= r.eye_x; req_ch.eye_y <= r.eye_y; req_ch.eye_z <= r.eye_z;
      req_ch.aim_x <= r.aim_x; req_ch.aim_y <= r.aim_y; req_ch.aim_z <= r.aim_z;
      req_ch.hint_x <= r.hint_x; req_ch.hint_y <= r.hint_y; req_ch.hint_z <= r.hint_z;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_empty();
      req_ch.valid <= 1'b0;
      while (pending_views.size() != 0) @(posedge clock);
   endtask

   // Directed rows: degenerate cases carry their typed-in result, the rest use the predictor.
   view_row_type rows[$];

   task automatic add_row(input view_req_type r, input bit known_flag,
                          input view_rsp_type k);
      view_row_type row;
      row.req = r;
      row.has_known = known_flag;
      row.known = k;
      rows.push_back(row);
   endtask

   initial begin
      view_rsp_type zero_view, z_only, any;
      view_req_type r;
      fail_count = 0;
      cycle_count = 0;
      idle_pct_req = 0;
      idle_pct_rsp = 0;
      hold_rsp = 1'b0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      r = make_req(0, 0, 0, 0, 0, 0, 0, 0, 0);
      req_ch.eye_x <= 0; req_ch.eye_y <= 0; req_ch.eye_z <= 0;
      req_ch.aim_x <= 0; req_ch.aim_y <= 0; req_ch.aim_z <= 0;
      req_ch.hint_x <= 0; req_ch.hint_y <= 0; req_ch.hint_z <= 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      zero_view = '{default: 0};
      any = zero_view;
      // Forward straight along +z with the eye one unit up the z axis: side and up
      // vanish, and the forward translation is minus one.
      z_only = zero_view;
      z_only.fwd_z = ONE_AXIS;
      z_only.shift_fwd = -32'sh10000;

      // Eye on the target: everything is zero, whatever the hint.
      add_row(make_req(0, 0, 0, 0, 0, 0, 0, ONE_POS, 0), 1, zero_view);
      add_row(make_req(MAXW, MINW, MAXW, MAXW, MINW, MAXW, MAXW, MAXW, MAXW), 1, zero_view);
      // Zero hint, and hint parallel to forward.
      add_row(make_req(0, 0, ONE_POS, 0, 0, 0, 0, 0, 0), 1, z_only);
      add_row(make_req(0, 0, ONE_POS, 0, 0, 0, 0, 0, ONE_POS), 1, z_only);
      add_row(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero_view);
      // Ordinary cameras and the field extremes.
      add_row(make_req(0, 0, ONE_POS * 5, 0, 0, 0, 0, ONE_POS, 0), 0, any);
      add_row(make_req(ONE_POS, ONE_POS * 2, ONE_POS * 3, 0, 0, 0, 0, ONE_POS, 0), 0, any);
      add_row(make_req(MAXW, MAXW, MAXW, MINW, MINW, MINW, MAXW, MINW, MAXW), 0, any);
      add_row(make_req(MINW, MINW, MINW, MAXW, MAXW, MAXW, MINW, MINW, MINW), 0, any);
      add_row(make_req(MAXW, MINW, 0, MINW, MAXW, 0, 0, 0, MAXW), 0, any);
      add_row(make_req(MINW, 0, MAXW, 0, MAXW, MINW, MAXW, MAXW, MINW), 0, any);
      add_row(make_req(-1, -1, -1, 0, 0, 0, 1, 0, 0), 0, any);
      add_row(make_req(1, 0, 0, 0, 0, 0, 0, 1, 0), 0, any);
      add_row(make_req(MAXW, MAXW, MAXW, 0, 0, 0, -1, -1, -1), 0, any);
      add_row(make_req(-32'sd5, 32'sd7, -32'sd3, 32'sd2, -32'sd9, 32'sd4, 0, 0, -1), 0, any);

      foreach (rows[i]) begin
         pending_views.push_back(rows[i].has_known ? rows[i].known
                                                   : predict_view(rows[i].req));
         send_req(rows[i].req);
      end

      // Random part in idling phases: none, sender idle, receiver stalls, both.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         case (n * 4 / RANDOM_ITEMS)
            0: begin idle_pct_req = 0;  idle_pct_rsp = 0;  end
            1: begin idle_pct_req = 50; idle_pct_rsp = 0;  end
            2: begin idle_pct_req = 0;  idle_pct_rsp = 50; end
            default: begin idle_pct_req = 28; idle_pct_rsp = 28; end
         endcase
         // Long receiver hold-off with the sender still offering, so the pipe backs up.
         if (n == 100) hold_rsp = 1'b1;
         if (n == 700) hold_rsp = 1'b0;
         // Sender pauses until the pipeline has drained completely.
         if (n == 900) wait_empty();
         r = rand_req();
         pending_views.push_back(predict_view(r));
         send_req(r);
      end
      hold_rsp = 1'b0;
      wait_empty();
      repeat (DRAIN_WAIT) @(posedge clock);

      if (fail_count == 0) begin
         $display("PASS view_matrix_look_at");
      end else begin
         $display("FAIL view_matrix_look_at");
      end
      $finish;
   end

endmodule
